FILE: hw/rtl/slcp_pkg.sv
// ----------------------------------------------------------------------------
// slcp_pkg
// Shared types, codes and the keyword table of the serial line LED command
// parser.
// ----------------------------------------------------------------------------
package slcp_pkg;

   localparam int LINE_SLOTS = 21;
   localparam int IDX_W      = $clog2(LINE_SLOTS);
   localparam int CNT_W      = $clog2(LINE_SLOTS + 1);

   typedef logic [7:0]       byte_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [2:0]       code_type;
   typedef logic [4:0]       levels_type;

   localparam byte_type BYTE_CR  = 8'h0D;
   localparam byte_type BYTE_DEL = 8'h7F;
   localparam byte_type CHAR_R   = 8'h72;
   localparam byte_type CHAR_A   = 8'h61;
   localparam byte_type CHAR_G   = 8'h67;
   localparam byte_type CHAR_B   = 8'h62;
   localparam byte_type CHAR_F   = 8'h66;
   localparam byte_type CHAR_N   = 8'h6E;
   localparam byte_type CHAR_T   = 8'h74;

   localparam code_type OUT_SELECT = 3'd0;
   localparam code_type OUT_OFF    = 3'd1;
   localparam code_type OUT_ON     = 3'd2;
   localparam code_type OUT_TOGGLE = 3'd3;
   localparam code_type OUT_REJECT = 3'd4;
   localparam code_type OUT_NONE   = 3'd5;

   localparam code_type PIN_ZERO   = 3'd0;
   localparam code_type PIN_RED    = 3'd1;
   localparam code_type PIN_BLUE   = 3'd2;
   localparam code_type PIN_ORANGE = 3'd3;
   localparam code_type PIN_GREEN  = 3'd4;

   localparam int NUM_WORDS = 7;
   localparam int WORD_MAX  = 6;

   // red, blue, orange, green, on, off, toggle; unused slots are zero
   localparam byte_type WORD_CHARS [NUM_WORDS][WORD_MAX] = '{
      '{8'h72, 8'h65, 8'h64, 8'h00, 8'h00, 8'h00},
      '{8'h62, 8'h6C, 8'h75, 8'h65, 8'h00, 8'h00},
      '{8'h6F, 8'h72, 8'h61, 8'h6E, 8'h67, 8'h65},
      '{8'h67, 8'h72, 8'h65, 8'h65, 8'h6E, 8'h00},
      '{8'h6F, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6F, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00},
      '{8'h74, 8'h6F, 8'h67, 8'h67, 8'h6C, 8'h65}
   };
   localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{
      3'd3, 3'd4, 3'd6, 3'd5, 3'd2, 3'd3, 3'd6
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      LB_NOP,
      LB_PUT,
      LB_DEL,
      LB_WRAP,
      LB_TERM,
      LB_CLEAR
   } lb_op_type;

   typedef struct packed {
      lb_op_type op;
      byte_type  data;
   } lb_cmd_type;

   typedef struct packed {
      logic     full;
      byte_type pos0;
      byte_type pos1;
      byte_type pos2;
      byte_type scan_byte;
   } lb_stat_type;

endpackage

FILE: hw/rtl/serial_line_led_command_parser_unit.sv
// ----------------------------------------------------------------------------
// serial_line_led_command_parser_unit
// An ordinary, delete or overflow byte only edits the line store and gives
// no result. A carriage return is accepted, then the line is walked through
// the single position compare unit until its terminator or the first byte
// that fits no keyword (at most 6 matched bytes); the result is then held
// until taken. One line at a time: after a carriage return no byte is taken
// until the result leaves.
// Reset (synchronous): line store and fill count zero, pin zero, levels low.
// ----------------------------------------------------------------------------
module serial_line_led_command_parser_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  slcp_pkg::byte_type    req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output slcp_pkg::code_type    rsp_outcome,
   output slcp_pkg::code_type    rsp_selected_pin,
   output slcp_pkg::levels_type  rsp_pin_levels
);
   import slcp_pkg::*;

   lb_cmd_type  cmd;
   lb_stat_type stat;
   idx_type     scan_addr;
   logic        match;

   slcp_line_buf u_line_buf (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .scan_addr (scan_addr),
      .stat      (stat)
   );

   slcp_word_match u_word_match (
      .pos   (scan_addr),
      .data  (stat.scan_byte),
      .match (match)
   );

   slcp_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_outcome      (rsp_outcome),
      .rsp_selected_pin (rsp_selected_pin),
      .rsp_pin_levels   (rsp_pin_levels),
      .stat             (stat),
      .match            (match),
      .cmd              (cmd),
      .scan_addr        (scan_addr)
   );

endmodule

FILE: hw/rtl/slcp_word_match.sv
// ----------------------------------------------------------------------------
// slcp_word_match
// Position compare unit: true when a byte equals the same position of any
// keyword. Positions at or past a word's length never match it.
// ----------------------------------------------------------------------------
module slcp_word_match (
   input  slcp_pkg::idx_type  pos,
   input  slcp_pkg::byte_type data,
   output logic               match
);
   import slcp_pkg::*;

   always_comb begin
      match = 1'b0;
      for (int w = 0; w < NUM_WORDS; w++) begin
         if (pos < IDX_W'(WORD_LEN[w]) && WORD_CHARS[w][pos[2:0]] == data) begin
            match = 1'b1;
         end
      end
   end

endmodule

FILE: hw/rtl/slcp_line_buf.sv
// ----------------------------------------------------------------------------
// slcp_line_buf
// Line store and fill count. Takes one edit command per cycle and exposes
// the fixed key positions plus one scanned position.
// ----------------------------------------------------------------------------
module slcp_line_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  slcp_pkg::lb_cmd_type   cmd,
   input  slcp_pkg::idx_type      scan_addr,
   output slcp_pkg::lb_stat_type  stat
);
   import slcp_pkg::*;

   byte_type store_ff [LINE_SLOTS];
   byte_type store_in [LINE_SLOTS];
   cnt_type  fill_ff;
   cnt_type  fill_in;
   cnt_type  fill_dec;

   assign fill_dec = fill_ff - 1'b1;

   always_comb begin
      store_in = store_ff;
      fill_in  = fill_ff;
      case (cmd.op)
         LB_PUT: begin
            store_in[fill_ff[IDX_W-1:0]] = cmd.data;
            fill_in = fill_ff + 1'b1;
         end
         LB_DEL: begin
            if (fill_ff != '0) begin
               store_in[fill_dec[IDX_W-1:0]] = '0;
               fill_in = fill_dec;
            end
         end
         LB_WRAP: begin
            // overflow: only the first slot is cleared, the rest stays stale
            store_in[0] = '0;
            fill_in     = '0;
         end
         LB_TERM: begin
            store_in[fill_ff[IDX_W-1:0]] = '0;
         end
         LB_CLEAR: begin
            for (int i = 0; i < LINE_SLOTS; i++) begin
               store_in[i] = '0;
            end
            fill_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE_SLOTS; i++) begin
            store_ff[i] <= '0;
         end
         fill_ff <= '0;
      end else begin
         store_ff <= store_in;
         fill_ff  <= fill_in;
      end
   end

   assign stat.full      = (fill_ff > CNT_W'(LINE_SLOTS - 1));
   assign stat.pos0      = store_ff[0];
   assign stat.pos1      = store_ff[1];
   assign stat.pos2      = store_ff[2];
   assign stat.scan_byte = store_ff[scan_addr];

endmodule

FILE: hw/rtl/slcp_ctrl.sv
// ----------------------------------------------------------------------------
// slcp_ctrl
// Sequencer: edits the line per received item, walks the line through the
// position compare unit on carriage return, applies the command and holds
// the result until taken.
// ----------------------------------------------------------------------------
module slcp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  slcp_pkg::byte_type     req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output slcp_pkg::code_type     rsp_outcome,
   output slcp_pkg::code_type     rsp_selected_pin,
   output slcp_pkg::levels_type   rsp_pin_levels,
   input  slcp_pkg::lb_stat_type  stat,
   input  logic                   match,
   output slcp_pkg::lb_cmd_type   cmd,
   output slcp_pkg::idx_type      scan_addr
);
   import slcp_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   idx_type    idx_ff;
   idx_type    idx_in;
   code_type   outcome_ff;
   code_type   outcome_in;
   code_type   chosen_ff;
   code_type   chosen_in;
   levels_type levels_ff;
   levels_type levels_in;
   levels_type pin_bit;
   logic       accept;
   logic       line_end;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign line_end  = (stat.scan_byte == '0);
   assign pin_bit   = levels_type'(1) << chosen_ff;
   assign scan_addr = idx_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !stat.full && req_rx_byte == BYTE_CR) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (line_end || !match) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands and datapath
   always_comb begin
      cmd.op     = LB_NOP;
      cmd.data   = req_rx_byte;
      idx_in     = idx_ff;
      outcome_in = outcome_ff;
      chosen_in  = chosen_ff;
      levels_in  = levels_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept) begin
               if (stat.full) begin
                  cmd.op = LB_WRAP;
               end else if (req_rx_byte == BYTE_CR) begin
                  cmd.op = LB_TERM;
               end else if (req_rx_byte == BYTE_DEL) begin
                  cmd.op = LB_DEL;
               end else begin
                  cmd.op = LB_PUT;
               end
            end
         end
         ST_SCAN: begin
            if (line_end) begin
               cmd.op     = LB_CLEAR;
               outcome_in = OUT_NONE;
               if (stat.pos0 == CHAR_R) begin
                  chosen_in  = PIN_RED;
                  outcome_in = OUT_SELECT;
               end else if (stat.pos2 == CHAR_A) begin
                  chosen_in  = PIN_ORANGE;
                  outcome_in = OUT_SELECT;
               end else if (stat.pos0 == CHAR_G) begin
                  chosen_in  = PIN_GREEN;
                  outcome_in = OUT_SELECT;
               end else if (stat.pos0 == CHAR_B) begin
                  chosen_in  = PIN_BLUE;
                  outcome_in = OUT_SELECT;
               end else if (stat.pos1 == CHAR_F) begin
                  levels_in  = levels_ff & ~pin_bit;
                  outcome_in = OUT_OFF;
               end else if (stat.pos1 == CHAR_N) begin
                  levels_in  = levels_ff | pin_bit;
                  outcome_in = OUT_ON;
               end else if (stat.pos0 == CHAR_T) begin
                  levels_in  = levels_ff ^ pin_bit;
                  outcome_in = OUT_TOGGLE;
               end
            end else if (!match) begin
               cmd.op     = LB_CLEAR;
               outcome_in = OUT_REJECT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         chosen_ff <= PIN_ZERO;
         levels_ff <= '0;
      end else begin
         state_ff  <= state_in;
         chosen_ff <= chosen_in;
         levels_ff <= levels_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      outcome_ff <= outcome_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_RESP);
   assign rsp_outcome      = outcome_ff;
   assign rsp_selected_pin = chosen_ff;
   assign rsp_pin_levels   = levels_ff;

endmodule

FILE: sim/serial_line_led_command_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// serial_line_led_command_parser_unit_tb
// Drives received bytes into the line parser and checks every line result
// against a cycle-free model of the line store, pin choice and pin levels.
// A short table of hand-written lines comes first, then random lines: keyword
// prefixes, edits, junk, overflowing lines. Sender and receiver both idle.
// ----------------------------------------------------------------------------
module serial_line_led_command_parser_unit_tb;
   import slcp_pkg::*;

   localparam int RANDOM_ITEMS  = 1000;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam int DIRECTED_ROWS = 26;

   typedef struct packed {
      code_type   outcome;
      code_type   pin;
      levels_type levels;
   } line_result_type;

   typedef struct packed {
      byte_type        rx;
      bit              typed;
      line_result_type res;
   } plan_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   byte_type   req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   code_type   rsp_outcome;
   code_type   rsp_selected_pin;
   levels_type rsp_pin_levels;

   serial_line_led_command_parser_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_outcome      (rsp_outcome),
      .rsp_selected_pin (rsp_selected_pin),
      .rsp_pin_levels   (rsp_pin_levels)
   );

   string keywords [NUM_WORDS] = '{"red", "blue", "orange", "green", "on", "off", "toggle"};

   // model of the block
   byte_type   line_buf [LINE_SLOTS] = '{default: '0};
   int         fill_level   = 0;
   code_type   model_pin    = PIN_ZERO;
   levels_type model_levels = '0;

   line_result_type line_results_due [$];
   int           mismatches  = 0;
   int           live_items  = 0;
   int           burst_left  = 0;
   bit           hold_request = 1'b0;

   // hand-written lines; the typed result is used where given
   plan_row_type directed_plan [DIRECTED_ROWS] = '{
      '{BYTE_CR,  1'b1, '{OUT_NONE,   PIN_ZERO,   5'h00}},
      '{"o",      1'b0, '0},
      '{"n",      1'b0, '0},
      '{BYTE_CR,  1'b1, '{OUT_ON,     PIN_ZERO,   5'h01}},
      '{CHAR_R,   1'b0, '0},
      '{BYTE_CR,  1'b1, '{OUT_SELECT, PIN_RED,    5'h01}},
      '{CHAR_T,   1'b0, '0},
      '{BYTE_CR,  1'b1, '{OUT_TOGGLE, PIN_RED,    5'h03}},
      '{"x",      1'b0, '0},
      '{BYTE_DEL, 1'b0, '0},
      '{"o",      1'b0, '0},
      '{CHAR_F,   1'b0, '0},
      '{BYTE_CR,  1'b1, '{OUT_OFF,    PIN_RED,    5'h01}},
      '{BYTE_DEL, 1'b0, '0},
      '{8'hFF,    1'b0, '0},
      '{BYTE_CR,  1'b1, '{OUT_REJECT, PIN_RED,    5'h01}},
      '{8'h00,    1'b0, '0},
      '{BYTE_CR,  1'b1, '{OUT_NONE,   PIN_RED,    5'h01}},
      '{CHAR_B,   1'b0, '0},
      '{BYTE_CR,  1'b1, '{OUT_SELECT, PIN_BLUE,   5'h01}},
      '{CHAR_G,   1'b0, '0},
      '{BYTE_CR,  1'b1, '{OUT_SELECT, PIN_GREEN,  5'h01}},
      '{"o",      1'b0, '0},
      '{"r",      1'b0, '0},
      '{CHAR_A,   1'b0, '0},
      '{BYTE_CR,  1'b1, '{OUT_SELECT, PIN_ORANGE, 5'h01}}
   };

   function automatic bit fits_word(input int pos, input byte_type b);
      for (int w = 0; w < NUM_WORDS; w++)
         if (pos < keywords[w].len() && byte_type'(keywords[w][pos]) == b) return 1'b1;
      return 1'b0;
   endfunction

   // advance the model by one byte; returns 1 when the byte closes a line
   function automatic bit parse_byte(input byte_type rx, output line_result_type res);
      bit         clean;
      levels_type mask;
      res = '0;
      if (fill_level > LINE_SLOTS - 1) begin
         // full line: byte dropped, only position 0 cleared
         line_buf[0] = '0;
         fill_level = 0;
         return 1'b0;
      end
      if (rx == BYTE_DEL) begin
         if (fill_level > 0) begin
            fill_level--;
            line_buf[fill_level] = '0;
         end
         return 1'b0;
      end
      if (rx != BYTE_CR) begin
         line_buf[fill_level] = rx;
         fill_level++;
         return 1'b0;
      end
      line_buf[fill_level] = '0;
      clean = 1'b1;
      for (int i = 0; i < LINE_SLOTS && line_buf[i] != 8'h00; i++)
         if (!fits_word(i, line_buf[i])) clean = 1'b0;
      mask = levels_type'(1) << model_pin;
      res.outcome = OUT_NONE;
      // key letters look at the whole store, stale bytes included
      if (!clean) res.outcome = OUT_REJECT;
      else if (line_buf[0] == CHAR_R) begin
         model_pin = PIN_RED;
         res.outcome = OUT_SELECT;
      end else if (line_buf[2] == CHAR_A) begin
         model_pin = PIN_ORANGE;
         res.outcome = OUT_SELECT;
      end else if (line_buf[0] == CHAR_G) begin
         model_pin = PIN_GREEN;
         res.outcome = OUT_SELECT;
      end else if (line_buf[0] == CHAR_B) begin
         model_pin = PIN_BLUE;
         res.outcome = OUT_SELECT;
      end else if (line_buf[1] == CHAR_F) begin
         model_levels &= ~mask;
         res.outcome = OUT_OFF;
      end else if (line_buf[1] == CHAR_N) begin
         model_levels |= mask;
         res.outcome = OUT_ON;
      end else if (line_buf[0] == CHAR_T) begin
         model_levels ^= mask;
         res.outcome = OUT_TOGGLE;
      end
      line_buf = '{default: '0};
      fill_level = 0;
      res.pin = model_pin;
      res.levels = model_levels;
      return 1'b1;
   endfunction

   function automatic byte_type plain_byte();
      byte_type b;
      b = byte_type'($urandom_range(0, 255));
      if (b == BYTE_CR || b == BYTE_DEL) b = b ^ 8'h80;
      return b;
   endfunction

   function automatic byte_type key_letter();
      string pool;
      pool = "ranfgbteo";
      return pool[$urandom_range(0, pool.len() - 1)];
   endfunction

   task automatic note_fault(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic offer_byte(input byte_type rx, input bit typed,
                             input line_result_type typed_res);
      line_result_type res;
      int           gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      if (!(rx == BYTE_DEL && fill_level == 0) && fill_level < LINE_SLOTS) live_items++;
      if (parse_byte(rx, res)) line_results_due.push_back(typed ? typed_res : res);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 25);
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_byte(input byte_type rx);
      offer_byte(rx, 1'b0, '0);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: changing stall patterns, plus one long hold-off on request
   initial begin
      int mode;
      int phase;
      rsp_stall = 1'b0;
      mode = 0;
      phase = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            phase++;
            if (phase % 150 == 0) mode = $urandom_range(0, 3);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= 1'($urandom_range(0, 1));
               2: rsp_stall <= (phase % 7) < 3;
               default: rsp_stall <= ($urandom_range(0, 9) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_results
      line_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (line_results_due.size() == 0)
            note_fault($sformatf("result with nothing pending: outcome %0d pin %0d levels %h",
                                 rsp_outcome, rsp_selected_pin, rsp_pin_levels));
         else begin
            want = line_results_due.pop_front();
            if (rsp_outcome !== want.outcome)
               note_fault($sformatf("outcome: expected %0d, got %0d", want.outcome, rsp_outcome));
            if (rsp_selected_pin !== want.pin)
               note_fault($sformatf("selected_pin: expected %0d, got %0d",
                                    want.pin, rsp_selected_pin));
            if (rsp_pin_levels !== want.levels)
               note_fault($sformatf("pin_levels: expected %h, got %h",
                                    want.levels, rsp_pin_levels));
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int    line_no;
      int    dice;
      int    n;
      int    k;
      int    dels;
      string word;
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++)
         offer_byte(directed_plan[r].rx, directed_plan[r].typed, directed_plan[r].res);

      live_items = 0;
      line_no = 0;
      while (live_items < RANDOM_ITEMS) begin
         if (line_no == 40) hold_request = 1'b1;
         if (line_no == 120) begin
            // idle the sender so the last item is not offered again while waiting
            @(negedge clock);
            req_valid <= 1'b0;
            wait (line_results_due.size() == 0);
         end
         dice = (line_no == 0) ? 75 : $urandom_range(0, 99);
         word = keywords[$urandom_range(0, NUM_WORDS - 1)];
         if (dice < 55) begin
            // keyword prefix, now and then a typo fixed by delete
            n = $urandom_range(1, word.len());
            for (k = 0; k < n; k++) begin
               if ($urandom_range(0, 11) == 0) begin
                  send_byte(plain_byte());
                  send_byte(BYTE_DEL);
               end
               send_byte(word[k]);
            end
            send_byte(BYTE_CR);
         end else if (dice < 65) begin
            // keyword prefix followed by a stray byte
            n = $urandom_range(0, word.len());
            for (k = 0; k < n; k++) send_byte(word[k]);
            send_byte(byte_type'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) send_byte(key_letter());
            send_byte(BYTE_CR);
         end else if (dice < 75) begin
            n = $urandom_range(0, 7);
            for (k = 0; k < n; k++) send_byte(byte_type'($urandom_range(0, 255)));
            send_byte(BYTE_CR);
         end else if (dice < 82) begin
            // overflow: fill the store, lose one byte, then a short line over stale bytes
            for (k = 0; k < LINE_SLOTS; k++) send_byte((k % 2) ? key_letter() : plain_byte());
            send_byte(byte_type'($urandom_range(0, 255)));
            n = $urandom_range(0, 2);
            for (k = 0; k < n; k++) send_byte(word[k]);
            send_byte(BYTE_CR);
         end else if (dice < 90) begin
            n = $urandom_range(1, word.len());
            for (k = 0; k < n; k++) send_byte(word[k]);
            dels = $urandom_range(1, n + 2);
            repeat (dels) send_byte(BYTE_DEL);
            if ($urandom_range(0, 1))
               for (k = (dels > n) ? 0 : n - dels; k < n; k++) send_byte(word[k]);
            send_byte(BYTE_CR);
         end else begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) send_byte(plain_byte());
            if ($urandom_range(0, 1)) send_byte(BYTE_CR);
         end
         line_no++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (line_results_due.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
